// ===== sv/bsr_pkg.sv =====
// shared constants and codes of the bilinear sampler
package bsr_pkg;

  localparam int COORD_W   = 20;
  localparam int PIX_W     = 16;
  localparam int ADDR_W    = 16;
  localparam int OUT_W     = 24;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int LANES     = 4;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 8;

  localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

// ===== sv/bsr_store.sv =====
// pixel store, one copy per neighbor so four reads go out each cycle
module bsr_store import bsr_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [PIX_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i [LANES],
  output logic [PIX_W-1:0]  rdata_o [LANES]
);

  for (genvar g = 0; g < LANES; g++) begin : g_copy
    logic [PIX_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk_i) begin
      if (we_i) begin
        mem[waddr_i] <= wdata_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (re_i) begin
        rdata_o[g] <= mem[raddr_i[g]];
      end
    end
  end

endmodule

// ===== sv/bsr_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module bsr_div #(
  parameter int NW = 40,
  parameter int DW = 17,
  parameter int QW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic          tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic          tag_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] nq_q  [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] v_q;
  logic [QW-1:0] tag_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic          v_in;
    logic          tag_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      // upper numerator bits are known to be below the divisor
      assign rem_in = DW'(num_i[NW-1:QW]);
      assign nq_in  = num_i[QW-1:0];
      assign den_in = den_i;
      assign v_in   = valid_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
      assign v_in   = v_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {rem_in, nq_in[QW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        nq_q[k]  <= {nq_in[QW-2:0], ge};
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = nq_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// ===== sv/bilinear_sample_with_border_renorm.sv =====
// top level of the bilinear sampler with border renormalization
//
// usage
// - one input channel (in_valid_i / in_ready_o) carries two kinds of request:
//   func_i = write stores pixel_value_i at pixel_addr_i, func_i = query asks
//   for the bilinear sample at (sample_x_i, sample_y_i), signed Q12.8
// - a query gives one result on the output channel (out_valid_o / out_ready_i);
//   a write gives none
// - image_width / image_height are set through cfg_we_i, cfg_index_i,
//   cfg_data_i while no request is in flight
// - throughput is one request per cycle while the output is not stalled; a
//   query result passes through the store read, two multiply stages, the
//   sum stage and the divider, which resolves one quotient bit per stage
// - the whole pipeline moves as one; while the receiver stalls a held result
//   the pipeline freezes and in_ready_o drops
// - reset empties the pipeline and sets both image dimensions to 256; the
//   pixel store is not cleared and must be written before it is read
module bilinear_sample_with_border_renorm import bsr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [ADDR_W-1:0]         pixel_addr_i,
  input  logic [PIX_W-1:0]          pixel_value_i,
  input  logic signed [COORD_W-1:0] sample_x_i,
  input  logic signed [COORD_W-1:0] sample_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [OUT_W-1:0]          sample_value_o,
  output logic                      sample_valid_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i
);

  localparam int F  = FRAC_BITS;
  localparam int CW = COORD_W - F;        // integer part of a coordinate
  localparam int WW = F + 1;              // one axis weight
  localparam int PW = 2 * F + 1;          // neighbor weight and weight sum
  localparam int TW = PIX_W + 2 * F;      // weighted pixel sum
  localparam int QW = PIX_W + F;          // quotient
  localparam int NW = TW + F;             // numerator

  // config registers
  logic [CFG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the pipeline advances whenever the output register can move
  logic en, accept, s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && in_ready_o;

  // dimensions saturate at the parameter limits
  logic [CFG_W-1:0] img_w, img_h;
  assign img_w = (32'(width_q) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_q;
  assign img_h = (32'(height_q) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_q;

  // integer corner and fractions, floor via arithmetic shift
  logic signed [CW-1:0] x0, y0;
  logic signed [CW:0]   x1, y1;
  logic [F-1:0]         fx, fy;
  logic                 x0_in, x1_in, y0_in, y1_in;
  logic [WW-1:0]        one, wx0, wx1, wy0, wy1;

  assign x0 = sample_x_i[COORD_W-1:F];
  assign y0 = sample_y_i[COORD_W-1:F];
  assign fx = sample_x_i[F-1:0];
  assign fy = sample_y_i[F-1:0];
  assign x1 = {x0[CW-1], x0} + (CW+1)'(1);
  assign y1 = {y0[CW-1], y0} + (CW+1)'(1);

  assign x0_in = !x0[CW-1] && (32'($unsigned(x0)) < 32'(img_w));
  assign x1_in = !x1[CW]   && (32'($unsigned(x1)) < 32'(img_w));
  assign y0_in = !y0[CW-1] && (32'($unsigned(y0)) < 32'(img_h));
  assign y1_in = !y1[CW]   && (32'($unsigned(y1)) < 32'(img_h));

  // neighbors outside the image lose their weight
  assign one = {1'b1, {F{1'b0}}};
  assign wx0 = x0_in ? WW'(one - {1'b0, fx}) : '0;
  assign wx1 = x1_in ? {1'b0, fx} : '0;
  assign wy0 = y0_in ? WW'(one - {1'b0, fy}) : '0;
  assign wy1 = y1_in ? {1'b0, fy} : '0;

  // store addresses modulo the depth; only low bits matter
  logic [ADDR_W-1:0] row0, row1, col0, w16;
  logic [ADDR_W-1:0] raddr [LANES];
  assign w16  = ADDR_W'(img_w);
  assign col0 = ADDR_W'(x0);
  assign row0 = ADDR_W'(ADDR_W'(y0) * w16);
  assign row1 = row0 + w16;
  assign raddr[0] = row0 + col0;                 // top left
  assign raddr[1] = row0 + col0 + ADDR_W'(1);    // top right
  assign raddr[2] = row1 + col0;                 // bottom left
  assign raddr[3] = row1 + col0 + ADDR_W'(1);    // bottom right

  // only one request per cycle, so a write and a read never share an edge
  logic [PIX_W-1:0] pix1 [LANES];
  bsr_store u_store (
    .clk_i   (clk_i),
    .we_i    (accept && (func_i == FUNC_WRITE)),
    .waddr_i (pixel_addr_i),
    .wdata_i (pixel_value_i),
    .re_i    (accept && (func_i == FUNC_QUERY)),
    .raddr_i (raddr),
    .rdata_o (pix1)
  );

  // stage 1: axis weights beside the read data
  logic [WW-1:0] wx0_q, wx1_q, wy0_q, wy1_q;
  // stage 2: neighbor weights
  logic [PW-1:0]    w2_q   [LANES];
  logic [PIX_W-1:0] pix2_q [LANES];
  // stage 3: weighted pixels
  logic [TW-1:0] prod3_q [LANES];
  logic [PW-1:0] sum3_q;
  // stage 4: divider operands
  logic [NW-1:0] num4_q;
  logic [PW-1:0] den4_q;
  logic          ok4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept && (func_i == FUNC_QUERY);
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx0_q <= wx0;
      wx1_q <= wx1;
      wy0_q <= wy0;
      wy1_q <= wy1;
      w2_q[0] <= PW'(wx0_q * wy0_q);
      w2_q[1] <= PW'(wx1_q * wy0_q);
      w2_q[2] <= PW'(wx0_q * wy1_q);
      w2_q[3] <= PW'(wx1_q * wy1_q);
      pix2_q  <= pix1;
      sum3_q  <= w2_q[0] + w2_q[1] + w2_q[2] + w2_q[3];
      num4_q  <= {prod3_q[0] + prod3_q[1] + prod3_q[2] + prod3_q[3], {F{1'b0}}};
      den4_q  <= sum3_q;
      ok4_q   <= (sum3_q != '0);
    end
  end

  // a zero-weight neighbor is still read, but its data is dropped here
  for (genvar g = 0; g < LANES; g++) begin : g_mul
    always_ff @(posedge clk_i) begin
      if (en) begin
        prod3_q[g] <= (w2_q[g] == '0) ? '0 : TW'(TW'(pix2_q[g]) * TW'(w2_q[g]));
      end
    end
  end

  logic [QW-1:0] quot;
  logic          ok_out;

  bsr_div #(
    .NW (NW),
    .DW (PW),
    .QW (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_valid_q),
    .num_i   (num4_q),
    .den_i   (den4_q),
    .tag_i   (ok4_q),
    .valid_o (out_valid_o),
    .quot_o  (quot),
    .tag_o   (ok_out)
  );

  // no neighbor inside carries weight: flagged invalid with a zero value
  assign sample_value_o = ok_out ? OUT_W'(quot) : '0;
  assign sample_valid_o = ok_out;

  a_ready_follows_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not track the output register");

  a_invalid_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sample_valid_o) |-> (sample_value_o == '0))
    else $error("invalid sample carries a value");

  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FUNC_WRITE)) |=> !s1_valid_q)
    else $error("write request entered the result pipeline");

  a_stall_freezes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && s4_valid_q) |=> s4_valid_q)
    else $error("pipeline moved during a stall");

endmodule
